[rtl/alm_pkg.sv]
package alm_pkg;

  // Field and state widths
  localparam int SAMPLE_W = 12;
  localparam int TIME_W   = 32;
  localparam int LEVEL_W  = 28;
  localparam int LVL_W    = 12;
  localparam int LIT_W    = 7;
  localparam int BRIGHT_W = 8;
  localparam int HUE_W    = 8;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // Default strip length
  localparam int BAR_LEDS_DEF = 64;

  // Level extremes
  localparam logic [LVL_W-1:0] LVL_TOP = 12'd4095;
  localparam logic [LVL_W-1:0] LVL_BOT = 12'd0;

  // Meter modes
  localparam logic [1:0] MODE_BAR   = 2'd0;
  localparam logic [1:0] MODE_PULSE = 2'd1;
  localparam logic [1:0] MODE_RANGE = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WEIGHT = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;
  localparam logic [1:0] REG_RANGE  = 2'd3;

  // Register reset values
  localparam logic [1:0]  MODE_RST   = MODE_RANGE;
  localparam logic [15:0] WEIGHT_RST = 16'd3277;
  localparam logic [15:0] PERIOD_RST = 16'd3000;
  localparam logic [11:0] RANGE_RST  = 12'd25;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   now_ms;
  } in_item_t;

  typedef struct packed {
    logic [LIT_W-1:0]    lit_count;
    logic [BRIGHT_W-1:0] level_brightness;
    logic [HUE_W-1:0]    hue_base;
    logic                range_valid;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  meter_mode;
    logic [15:0] smoothing_weight;
    logic [15:0] calibrate_period_ms;
    logic [11:0] min_valid_range;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LEVEL,
    S_MAP,
    S_SCALE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic mul;
    logic level;
    logic map;
    logic scale;
    logic div_start;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/alm_div.sv]
module alm_div #(
  parameter int DW = 20,
  parameter int VW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW);

  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [VW:0]   trial;
  logic [VW:0]   diff;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial    = {rem_r, quo_r[DW-1]};
    diff     = trial - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // Operand and quotient registers.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  // Busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

[rtl/alm_dp.sv]
module alm_dp #(
  parameter int BAR_LEDS = alm_pkg::BAR_LEDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  alm_pkg::dp_cmd_t    cmd,
  output alm_pkg::dp_status_t status,
  input  alm_pkg::cfg_t       cfg,
  input  alm_pkg::in_item_t   in_data,
  input  logic                out_stall,
  output logic                out_valid,
  output alm_pkg::out_item_t  out_data
);

  localparam int HALF     = BAR_LEDS / 2;
  localparam int BAR_W    = $clog2(BAR_LEDS + 1);
  localparam int SCW      = (BAR_W > 8) ? BAR_W : 8;
  localparam int DW       = alm_pkg::LVL_W + SCW;
  localparam int LIT_TOP  = (BAR_LEDS > 127) ? 127 : BAR_LEDS;
  localparam int HALF_TOP = (HALF > 127) ? 127 : HALF;

  localparam logic [DW-1:0]  LIT_TOP_Q  = DW'(LIT_TOP);
  localparam logic [DW-1:0]  HALF_TOP_Q = DW'(HALF_TOP);
  localparam logic [DW-1:0]  BRIGHT_Q   = DW'(255);
  localparam logic [SCW-1:0] SCALE_BAR  = SCW'(BAR_LEDS);
  localparam logic [SCW-1:0] SCALE_HALF = SCW'(HALF);
  localparam logic [SCW-1:0] SCALE_PUL  = SCW'(255);
  localparam logic [alm_pkg::LIT_W-1:0] LIT_TOP_L = alm_pkg::LIT_W'(LIT_TOP);

  alm_pkg::in_item_t  in_r;
  alm_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [alm_pkg::LEVEL_W-1:0] level_r, level_nxt;
  logic [alm_pkg::LEVEL_W-1:0] prod_new_r;
  logic [44:0]                 prod_old_r;
  logic [29:0]                 level_sum;

  logic [alm_pkg::LVL_W-1:0] min_r, min_nxt;
  logic [alm_pkg::LVL_W-1:0] max_r, max_nxt;
  logic                      span_r, span_nxt;
  logic [alm_pkg::TIME_W-1:0] last_r, last_nxt;
  logic [alm_pkg::HUE_W-1:0] hue_r, hue_nxt;

  logic [alm_pkg::LVL_W-1:0] mag_r, mag_nxt;
  logic [alm_pkg::LVL_W-1:0] divisor_r, divisor_nxt;
  logic                      neg_r, neg_nxt;
  logic                      zden_r, zden_nxt;
  logic [DW-1:0]             dividend_r;
  logic [SCW-1:0]            scale;

  logic [alm_pkg::LVL_W-1:0]  lvl;
  logic [alm_pkg::LVL_W-1:0]  min_upd, max_upd, min_fin, max_fin;
  logic [alm_pkg::TIME_W-1:0] elapsed;
  logic                       recal;
  logic signed [12:0]         span;
  logic                       span_ge;
  logic                       num_neg, den_neg;

  logic          div_busy;
  logic [DW-1:0] quotient;
  logic [DW:0]   recip_sum;
  logic [DW-1:0] quo_const;

  // Capture the input item on its transfer.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
  end

  // Smoothing products: w * sample and (1 - w) * level, both scaled by 2^16.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_new_r <= {12'd0, cfg.smoothing_weight} * {16'd0, in_r.sample};
      prod_old_r <= {28'd0, 17'h10000 - {1'b0, cfg.smoothing_weight}} * {17'd0, level_r};
    end
  end

  assign level_sum = {2'b00, prod_new_r} + {1'b0, prod_old_r[44:16]};
  assign level_nxt = cmd.level ? level_sum[alm_pkg::LEVEL_W-1:0] : level_r;
  assign lvl       = level_r[alm_pkg::LEVEL_W-1:16];

  // Running extremes, calibration window and the range mapping operands.
  always_comb begin
    min_upd = (lvl < min_r) ? lvl : min_r;
    max_upd = (lvl > max_r) ? lvl : max_r;
    elapsed = in_r.now_ms - last_r;
    recal   = elapsed >= {16'h0000, cfg.calibrate_period_ms};
    span    = $signed({1'b0, max_upd}) - $signed({1'b0, min_upd});
    span_ge = span >= $signed({1'b0, cfg.min_valid_range});
    min_fin = recal ? alm_pkg::LVL_TOP : min_upd;
    max_fin = recal ? alm_pkg::LVL_BOT : max_upd;
    num_neg = lvl < min_fin;
    den_neg = max_fin < min_fin;

    min_nxt     = min_r;
    max_nxt     = max_r;
    span_nxt    = span_r;
    last_nxt    = last_r;
    hue_nxt     = hue_r;
    mag_nxt     = mag_r;
    divisor_nxt = divisor_r;
    neg_nxt     = neg_r;
    zden_nxt    = zden_r;
    if (cmd.map) begin
      case (cfg.meter_mode)
        alm_pkg::MODE_BAR: begin
          hue_nxt     = hue_r + 8'd2;
          mag_nxt     = lvl;
          divisor_nxt = alm_pkg::LVL_TOP;
          neg_nxt     = 1'b0;
          zden_nxt    = 1'b0;
        end
        alm_pkg::MODE_PULSE: begin
          hue_nxt     = hue_r + 8'd1;
          mag_nxt     = lvl;
          divisor_nxt = alm_pkg::LVL_TOP;
          neg_nxt     = 1'b0;
          zden_nxt    = 1'b0;
        end
        default: begin
          hue_nxt     = hue_r + 8'd1;
          min_nxt     = min_fin;
          max_nxt     = max_fin;
          if (recal) begin
            span_nxt = span_ge;
            last_nxt = in_r.now_ms;
          end
          mag_nxt     = num_neg ? (min_fin - lvl) : (lvl - min_fin);
          divisor_nxt = den_neg ? (min_fin - max_fin) : (max_fin - min_fin);
          neg_nxt     = num_neg ^ den_neg;
          zden_nxt    = max_fin == min_fin;
        end
      endcase
    end
  end

  // Meter state with its reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      min_r   <= alm_pkg::LVL_TOP;
      max_r   <= alm_pkg::LVL_BOT;
      span_r  <= 1'b0;
      last_r  <= '0;
      hue_r   <= '0;
    end else begin
      level_r <= level_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      span_r  <= span_nxt;
      last_r  <= last_nxt;
      hue_r   <= hue_nxt;
    end
  end

  // Division operands.
  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    divisor_r <= divisor_nxt;
    neg_r     <= neg_nxt;
    zden_r    <= zden_nxt;
  end

  // Scale the numerator by the target full-scale value of the mode.
  always_comb begin
    case (cfg.meter_mode)
      alm_pkg::MODE_BAR:   scale = SCALE_BAR;
      alm_pkg::MODE_PULSE: scale = SCALE_PUL;
      default:             scale = SCALE_HALF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      dividend_r <= {{SCW{1'b0}}, mag_r} * {{alm_pkg::LVL_W{1'b0}}, scale};
    end
  end

  alm_div #(
    .DW (DW),
    .VW (alm_pkg::LVL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend_r),
    .divisor  (divisor_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Division by 4095 for the bar and pulse modes: x / (2^12 - 1) equals
  // (x + (x >> 12) + 1) >> 12 while the quotient stays at or below 4096.
  assign recip_sum = {1'b0, dividend_r}
                   + {{(alm_pkg::LVL_W+1){1'b0}}, dividend_r[DW-1:alm_pkg::LVL_W]}
                   + {{DW{1'b0}}, 1'b1};
  assign quo_const = {{(alm_pkg::LVL_W-1){1'b0}}, recip_sum[DW:alm_pkg::LVL_W]};

  // Clamp the quotient into the result fields.
  always_comb begin
    out_nxt                  = out_r;
    out_valid_nxt            = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt            = 1'b1;
      out_nxt.lit_count        = '0;
      out_nxt.level_brightness = '0;
      out_nxt.hue_base         = hue_r;
      out_nxt.range_valid      = span_r;
      case (cfg.meter_mode)
        alm_pkg::MODE_BAR: begin
          out_nxt.lit_count = (quo_const > LIT_TOP_Q) ? LIT_TOP_L
                                                      : quo_const[alm_pkg::LIT_W-1:0];
        end
        alm_pkg::MODE_PULSE: begin
          out_nxt.level_brightness = (quo_const > BRIGHT_Q) ? 8'hFF
                                                            : quo_const[7:0];
        end
        default: begin
          if (span_r && !zden_r && !neg_r) begin
            out_nxt.lit_count = (quotient > HALF_TOP_Q) ?
                                HALF_TOP_Q[alm_pkg::LIT_W-1:0] :
                                quotient[alm_pkg::LIT_W-1:0];
          end
        end
      endcase
    end
  end

  // Output register, so a waiting result does not hold up the next item.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_r;
  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid_r || !out_stall;

  // A result is only loaded into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending transfer");

  // The divider is never restarted mid-run.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  // The lit count never exceeds the strip length.
  a_lit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.lit_count <= LIT_TOP_L))
    else $error("lit count out of range");

  // A stalled result stays valid and unchanged.
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result changed");

endmodule

[rtl/alm_ctrl.sv]
module alm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  alm_pkg::dp_status_t status,
  output alm_pkg::dp_cmd_t    cmd
);

  alm_pkg::state_t state_r, state_nxt;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      alm_pkg::S_IDLE:     if (in_valid) state_nxt = alm_pkg::S_MUL;
      alm_pkg::S_MUL:      state_nxt = alm_pkg::S_LEVEL;
      alm_pkg::S_LEVEL:    state_nxt = alm_pkg::S_MAP;
      alm_pkg::S_MAP:      state_nxt = alm_pkg::S_SCALE;
      alm_pkg::S_SCALE:    state_nxt = alm_pkg::S_DIV_GO;
      alm_pkg::S_DIV_GO:   state_nxt = alm_pkg::S_DIV_WAIT;
      alm_pkg::S_DIV_WAIT: if (!status.div_busy) state_nxt = alm_pkg::S_DONE;
      alm_pkg::S_DONE:     if (status.out_free) state_nxt = alm_pkg::S_IDLE;
      default:             state_nxt = alm_pkg::S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      alm_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      alm_pkg::S_MUL:      cmd.mul       = 1'b1;
      alm_pkg::S_LEVEL:    cmd.level     = 1'b1;
      alm_pkg::S_MAP:      cmd.map       = 1'b1;
      alm_pkg::S_SCALE:    cmd.scale     = 1'b1;
      alm_pkg::S_DIV_GO:   cmd.div_start = 1'b1;
      alm_pkg::S_DIV_WAIT: cmd           = '0;
      alm_pkg::S_DONE:     cmd.out_load  = status.out_free;
      default:             cmd           = '0;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= alm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/audio_level_meter_autorange.sv]
// Each item passes the multiply, level, map and scale steps and then the bit-serial divider,
// one quotient bit per cycle, before its result is loaded into the output register.
// The next item is taken while a result waits in the output register.
// Reset (rst_n, synchronous, active low) clears the level, min to 4095, max, range flag,
// calibration time and hue, and loads the register defaults (mode 2, weight 3277,
// period 3000 ms, range 25).
module audio_level_meter_autorange #(
  parameter int BAR_LEDS = alm_pkg::BAR_LEDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  alm_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output alm_pkg::out_item_t           out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [alm_pkg::ADDR_W-1:0]   paddr,
  input  logic [alm_pkg::DATA_W-1:0]   pwdata,
  output logic [alm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  alm_pkg::cfg_t       cfg_r, cfg_nxt;
  alm_pkg::dp_cmd_t    cmd;
  alm_pkg::dp_status_t status;
  logic                wr_en;
  logic [1:0]          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        alm_pkg::REG_MODE:   cfg_nxt.meter_mode          = pwdata[1:0];
        alm_pkg::REG_WEIGHT: cfg_nxt.smoothing_weight    = pwdata[15:0];
        alm_pkg::REG_PERIOD: cfg_nxt.calibrate_period_ms = pwdata[15:0];
        alm_pkg::REG_RANGE:  cfg_nxt.min_valid_range     = pwdata[11:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.meter_mode          <= alm_pkg::MODE_RST;
      cfg_r.smoothing_weight    <= alm_pkg::WEIGHT_RST;
      cfg_r.calibrate_period_ms <= alm_pkg::PERIOD_RST;
      cfg_r.min_valid_range     <= alm_pkg::RANGE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register read mux.
  always_comb begin
    unique case (reg_idx)
      alm_pkg::REG_MODE:   prdata = {30'd0, cfg_r.meter_mode};
      alm_pkg::REG_WEIGHT: prdata = {16'd0, cfg_r.smoothing_weight};
      alm_pkg::REG_PERIOD: prdata = {16'd0, cfg_r.calibrate_period_ms};
      alm_pkg::REG_RANGE:  prdata = {20'd0, cfg_r.min_valid_range};
      default:             prdata = '0;
    endcase
  end

  alm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  alm_dp #(
    .BAR_LEDS (BAR_LEDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
